>>> hw/rtl/compacting_entity_table_macros.svh
// Assertion macros used by the checker file.
`ifndef COMPACTING_ENTITY_TABLE_MACROS_SVH
`define COMPACTING_ENTITY_TABLE_MACROS_SVH

// same-cycle implication
`define CET_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("compacting_entity_table: assertion failed");

// next-cycle implication
`define CET_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("compacting_entity_table: assertion failed");

`endif

>>> hw/rtl/cet_pkg.sv
package cet_pkg;

  localparam int TABLE_DEPTH   = 32;
  localparam int COORD_WIDTH   = 32;
  localparam int IDX_W         = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W         = $clog2(TABLE_DEPTH + 1);
  localparam int ID_W          = 16;
  localparam int ENTRY_COUNT_W = 6;

  localparam logic [ID_W-1:0] FULL_ID = '1;

  localparam logic [1:0] ACT_CREATE  = 2'd0;
  localparam logic [1:0] ACT_DESTROY = 2'd1;
  localparam logic [1:0] ACT_GET     = 2'd2;
  localparam logic [1:0] ACT_SET     = 2'd3;

  localparam logic [1:0] ST_DONE      = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;

  localparam logic [1:0] WR_APPEND = 2'd0;
  localparam logic [1:0] WR_UPDATE = 2'd1;
  localparam logic [1:0] WR_SHIFT  = 2'd2;

  typedef struct packed {
    logic [ID_W-1:0]        id;
    logic [COORD_WIDTH-1:0] px;
    logic [COORD_WIDTH-1:0] py;
    logic [COORD_WIDTH-1:0] vx;
    logic [COORD_WIDTH-1:0] vy;
  } rec_t;

  typedef struct packed {
    logic       load_item;
    logic       rd_next;
    logic       wr_en;
    logic [1:0] wr_sel;
    logic       idx_inc;
    logic       res_full;
    logic       res_create;
    logic       res_nf;
    logic       res_get;
    logic       res_dec;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic [1:0] act;
    logic       full;
    logic       empty;
    logic       hit;
    logic       last;
    logic       more;
  } sts_t;

  function automatic logic [COORD_WIDTH-1:0] to_store(input logic signed [31:0] v);
    return COORD_WIDTH'(v);
  endfunction

  function automatic logic signed [31:0] from_store(input logic [COORD_WIDTH-1:0] s);
    return 32'(signed'(s));
  endfunction

endpackage

>>> hw/rtl/cet_ram.sv
module cet_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hw/rtl/cet_dp.sv
module cet_dp (
  input  logic                 clk,
  input  logic                 rst,
  input  cet_pkg::cmd_t        cmd,
  output cet_pkg::sts_t        sts,
  input  logic [1:0]           action,
  input  logic [15:0]          key_id,
  input  logic signed [31:0]   pos_x,
  input  logic signed [31:0]   pos_y,
  input  logic signed [31:0]   vel_x,
  input  logic signed [31:0]   vel_y,
  output logic [1:0]           status,
  output logic [15:0]          new_id,
  output logic signed [31:0]   out_pos_x,
  output logic signed [31:0]   out_pos_y,
  output logic signed [31:0]   out_vel_x,
  output logic signed [31:0]   out_vel_y,
  output logic [5:0]           entry_count
);
  import cet_pkg::*;

  logic [1:0]             act;
  logic [ID_W-1:0]        key;
  logic [COORD_WIDTH-1:0] vpx, vpy, vvx, vvy;
  logic [IDX_W-1:0]       idx;
  logic [CNT_W-1:0]       count;
  logic [CNT_W-1:0]       count_next;
  logic [ID_W-1:0]        id_ctr;
  logic [ID_W-1:0]        id_ctr_inc;

  logic [1:0]             p_status;
  logic [ID_W-1:0]        p_new_id;
  logic signed [31:0]     p_px, p_py, p_vx, p_vy;
  logic                   p_inc, p_dec;

  logic [IDX_W-1:0]       rd_addr;
  logic [IDX_W-1:0]       wr_addr;
  rec_t                   wr_rec;
  rec_t                   rd_rec;
  logic [CNT_W:0]         idx_ext;
  logic [CNT_W:0]         cnt_ext;

  assign id_ctr_inc = id_ctr + ID_W'(1);
  assign rd_addr    = cmd.rd_next ? idx + IDX_W'(1) : idx;
  assign idx_ext    = (CNT_W + 1)'(idx);
  assign cnt_ext    = (CNT_W + 1)'(count);
  assign count_next = count + CNT_W'(p_inc) - CNT_W'(p_dec);

  always_comb begin
    wr_addr = idx;
    wr_rec  = rd_rec;
    case (cmd.wr_sel)
      WR_APPEND: begin
        wr_addr = IDX_W'(count);
        wr_rec  = '{id: id_ctr_inc, px: vpx, py: vpy, vx: vvx, vy: vvy};
      end
      WR_UPDATE: begin
        wr_rec  = '{id: rd_rec.id, px: vpx, py: vpy, vx: vvx, vy: vvy};
      end
      default: begin
        wr_rec  = rd_rec;
      end
    endcase
  end

  cet_ram #(
    .WIDTH($bits(rec_t)),
    .DEPTH(TABLE_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (cmd.wr_en),
    .waddr(wr_addr),
    .wdata(wr_rec),
    .raddr(rd_addr),
    .rdata(rd_rec)
  );

  assign sts.act   = act;
  assign sts.full  = (count == CNT_W'(TABLE_DEPTH));
  assign sts.empty = (count == '0);
  assign sts.hit   = (rd_rec.id == key);
  assign sts.last  = (idx_ext + (CNT_W + 1)'(1)) >= cnt_ext;
  assign sts.more  = (idx_ext + (CNT_W + 1)'(2)) < cnt_ext;

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      id_ctr <= '0;
    end else begin
      if (cmd.res_create) begin
        id_ctr <= id_ctr_inc;
      end
      if (cmd.out_load) begin
        count <= count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      act      <= action;
      key      <= key_id;
      vpx      <= to_store(pos_x);
      vpy      <= to_store(pos_y);
      vvx      <= to_store(vel_x);
      vvy      <= to_store(vel_y);
      idx      <= '0;
      p_status <= ST_DONE;
      p_new_id <= '0;
      p_px     <= '0;
      p_py     <= '0;
      p_vx     <= '0;
      p_vy     <= '0;
      p_inc    <= 1'b0;
      p_dec    <= 1'b0;
    end else begin
      if (cmd.idx_inc) begin
        idx <= idx + IDX_W'(1);
      end
      if (cmd.res_full) begin
        p_status <= ST_FULL;
        p_new_id <= FULL_ID;
      end
      if (cmd.res_create) begin
        p_new_id <= id_ctr_inc;
        p_inc    <= 1'b1;
      end
      if (cmd.res_nf) begin
        p_status <= ST_NOT_FOUND;
      end
      if (cmd.res_get) begin
        p_px <= from_store(rd_rec.px);
        p_py <= from_store(rd_rec.py);
        p_vx <= from_store(rd_rec.vx);
        p_vy <= from_store(rd_rec.vy);
      end
      if (cmd.res_dec) begin
        p_dec <= 1'b1;
      end
    end
  end

  // result register: holds while the consumer stalls
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      status      <= p_status;
      new_id      <= p_new_id;
      out_pos_x   <= p_px;
      out_pos_y   <= p_py;
      out_vel_x   <= p_vx;
      out_vel_y   <= p_vy;
      entry_count <= ENTRY_COUNT_W'(count_next);
    end
  end

endmodule

>>> hw/rtl/cet_ctrl.sv
module cet_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  cet_pkg::sts_t sts,
  output cet_pkg::cmd_t cmd
);
  import cet_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECIDE = 3'd1;
  localparam logic [2:0] S_RD     = 3'd2;
  localparam logic [2:0] S_CMP    = 3'd3;
  localparam logic [2:0] S_SH_RD  = 3'd4;
  localparam logic [2:0] S_SH_WR  = 3'd5;
  localparam logic [2:0] S_DONE   = 3'd6;

  logic [2:0] state, state_next;
  logic       out_valid_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next     = state;
    cmd            = '0;
    cmd.wr_sel     = WR_SHIFT;
    cmd.load_item  = in_valid && in_ready;
    out_valid_next = out_valid && !out_ready;

    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (sts.act == ACT_CREATE) begin
          if (sts.full) begin
            cmd.res_full = 1'b1;
          end else begin
            cmd.wr_en      = 1'b1;
            cmd.wr_sel     = WR_APPEND;
            cmd.res_create = 1'b1;
          end
          state_next = S_DONE;
        end else if (sts.empty) begin
          cmd.res_nf = 1'b1;
          state_next = S_DONE;
        end else begin
          state_next = S_RD;
        end
      end
      S_RD: begin
        state_next = S_CMP;
      end
      S_CMP: begin
        if (sts.hit) begin
          state_next = S_DONE;
          unique case (sts.act)
            ACT_DESTROY: begin
              cmd.res_dec = 1'b1;
              if (!sts.last) begin
                state_next = S_SH_RD;
              end
            end
            ACT_GET: begin
              cmd.res_get = 1'b1;
            end
            ACT_SET: begin
              cmd.wr_en  = 1'b1;
              cmd.wr_sel = WR_UPDATE;
            end
            default: begin
              cmd.res_nf = 1'b1;
            end
          endcase
        end else if (sts.last) begin
          cmd.res_nf = 1'b1;
          state_next = S_DONE;
        end else begin
          cmd.idx_inc = 1'b1;
          state_next  = S_RD;
        end
      end
      S_SH_RD: begin
        cmd.rd_next = 1'b1;
        state_next  = S_SH_WR;
      end
      S_SH_WR: begin
        // move the record above idx down into idx
        cmd.wr_en   = 1'b1;
        cmd.wr_sel  = WR_SHIFT;
        cmd.idx_inc = 1'b1;
        state_next  = sts.more ? S_SH_RD : S_DONE;
      end
      S_DONE: begin
        if (!out_valid || out_ready) begin
          cmd.out_load   = 1'b1;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

>>> hw/rtl/compacting_entity_table.sv
// Dense table of up to 32 records (16-bit id, x/y position, x/y velocity),
// held in one single-port-read RAM and handled one item at a time. Create,
// and any lookup on an empty table, goes straight from the decide step to
// the result. Get, set and destroy scan from slot 0, with a RAM read and then
// the id compare for each record examined; destroy then moves every later
// record down by one slot, with a read and a write for each. A consumer that
// holds off a previous result also delays the current one.
// A new item is taken once the previous result sits in the output register,
// even if it is not yet taken.
module compacting_entity_table (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           action,
  input  logic [15:0]          key_id,
  input  logic signed [31:0]   pos_x,
  input  logic signed [31:0]   pos_y,
  input  logic signed [31:0]   vel_x,
  input  logic signed [31:0]   vel_y,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [1:0]           status,
  output logic [15:0]          new_id,
  output logic signed [31:0]   out_pos_x,
  output logic signed [31:0]   out_pos_y,
  output logic signed [31:0]   out_vel_x,
  output logic signed [31:0]   out_vel_y,
  output logic [5:0]           entry_count
);
  import cet_pkg::*;

  cmd_t cmd;
  sts_t sts;

  cet_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  cet_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .action     (action),
    .key_id     (key_id),
    .pos_x      (pos_x),
    .pos_y      (pos_y),
    .vel_x      (vel_x),
    .vel_y      (vel_y),
    .status     (status),
    .new_id     (new_id),
    .out_pos_x  (out_pos_x),
    .out_pos_y  (out_pos_y),
    .out_vel_x  (out_vel_x),
    .out_vel_y  (out_vel_y),
    .entry_count(entry_count)
  );

endmodule

>>> hw/rtl/cet_chk.sv
`include "compacting_entity_table_macros.svh"

module cet_chk (
  input logic                 clk,
  input logic                 rst,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic [1:0]           status,
  input logic [15:0]          new_id,
  input logic signed [31:0]   out_pos_x,
  input logic signed [31:0]   out_pos_y,
  input logic signed [31:0]   out_vel_x,
  input logic signed [31:0]   out_vel_y,
  input logic [5:0]           entry_count
);
  import cet_pkg::*;

  `CET_ASSERT_NXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(status) && $stable(new_id) && $stable(entry_count))
  `CET_ASSERT_IMP(a_full_marks, clk, rst, out_valid && status == ST_FULL, new_id == FULL_ID && entry_count == ENTRY_COUNT_W'(TABLE_DEPTH))
  `CET_ASSERT_IMP(a_fail_zero, clk, rst, out_valid && status != ST_DONE, out_pos_x == 0 && out_pos_y == 0 && out_vel_x == 0 && out_vel_y == 0)
  `CET_ASSERT_NXT(a_one_at_time, clk, rst, in_valid && in_ready, !in_ready)

endmodule

bind compacting_entity_table cet_chk u_chk (.*);
